// File: src/swrms_pkg.sv
// Shared constants, types and state encodings for the sliding-window RMS filter.
`timescale 1ns / 1ps

package swrms_pkg;

  localparam int WINDOW_MAX  = 256;
  localparam int SAMPLE_BITS = 16;

  localparam int WL_W       = 9;
  localparam int PL_W       = 16;
  localparam int RMS_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int PTR_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W     = $clog2(WINDOW_MAX + 1);
  localparam int SQ_W      = ((SAMPLE_BITS > 16) ? 2 * SAMPLE_BITS : 32) - 1;
  localparam int TOT_W     = SQ_W + PTR_W;
  localparam int ROOT_W    = (SQ_W + 1) / 2;
  localparam int SQRT_IN_W = 2 * ROOT_W;
  localparam int ITER_W    = $clog2(TOT_W);

  localparam logic [WL_W-1:0] WINDOW_RESET = WL_W'(16);

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PRIME_LEVEL   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_CALC,
    ST_DELIVER
  } ctrl_state_t;

  typedef enum logic [1:0] {
    DS_IDLE,
    DS_DIV,
    DS_SQRT,
    DS_DONE
  } ds_state_t;

  typedef struct packed {
    logic             start;
    logic [TOT_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } ds_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } ds_rsp_t;

endpackage

// File: src/swrms_ram.sv
// Single-port-write, single-port-read ring memory with registered read data.
`timescale 1ns / 1ps

module swrms_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 31
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: src/swrms_divsqrt.sv
// Bit-serial divide of the window total by N followed by a bit-serial square root.
`timescale 1ns / 1ps

module swrms_divsqrt (
  input  logic               clk,
  input  logic               rst_n,
  input  swrms_pkg::ds_req_t req,
  output swrms_pkg::ds_rsp_t rsp
);

  import swrms_pkg::*;

  ds_state_t state_r, state_nxt;
  logic [ITER_W-1:0]    iter_r;
  logic [CNT_W-1:0]     rem_r;
  logic [TOT_W-1:0]     quo_r;
  logic [CNT_W-1:0]     div_r;
  logic [ROOT_W+1:0]    srem_r;
  logic [ROOT_W-1:0]    root_r;
  logic [SQRT_IN_W-1:0] rad_r;

  logic [CNT_W:0]       trial;
  logic                 div_ge;
  logic [CNT_W-1:0]     rem_nxt;
  logic [TOT_W-1:0]     quo_nxt;

  logic [ROOT_W+3:0]    strial;
  logic [ROOT_W+3:0]    ssub;
  logic                 sqrt_ge;
  logic [ROOT_W+1:0]    srem_nxt;
  logic [ROOT_W-1:0]    root_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[TOT_W-1]};
    div_ge  = (trial >= {1'b0, div_r});
    rem_nxt = div_ge ? CNT_W'(trial - {1'b0, div_r}) : CNT_W'(trial);
    quo_nxt = {quo_r[TOT_W-2:0], div_ge};
  end

  always_comb begin
    strial   = {srem_r, rad_r[SQRT_IN_W-1 -: 2]};
    ssub     = (ROOT_W + 4)'({root_r, 2'b01});
    sqrt_ge  = (strial >= ssub);
    srem_nxt = sqrt_ge ? (ROOT_W + 2)'(strial - ssub) : (ROOT_W + 2)'(strial);
    root_nxt = {root_r[ROOT_W-2:0], sqrt_ge};
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      DS_IDLE: begin
        if (req.start) state_nxt = DS_DIV;
      end
      DS_DIV: begin
        if (iter_r == '0) state_nxt = DS_SQRT;
      end
      DS_SQRT: begin
        if (iter_r == '0) state_nxt = DS_DONE;
      end
      DS_DONE: begin
        state_nxt = DS_IDLE;
      end
      default: begin
        state_nxt = DS_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp.done = (state_r == DS_DONE);
    rsp.root = root_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      DS_IDLE: begin
        if (req.start) begin
          quo_r  <= req.dividend;
          div_r  <= req.divisor;
          rem_r  <= '0;
          iter_r <= ITER_W'(TOT_W - 1);
        end
      end
      DS_DIV: begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        if (iter_r == '0) begin
          rad_r  <= SQRT_IN_W'(quo_nxt[SQ_W-1:0]);
          srem_r <= '0;
          root_r <= '0;
          iter_r <= ITER_W'(ROOT_W - 1);
        end else begin
          iter_r <= iter_r - 1'b1;
        end
      end
      DS_SQRT: begin
        srem_r <= srem_nxt;
        root_r <= root_nxt;
        rad_r  <= {rad_r[SQRT_IN_W-3:0], 2'b00};
        iter_r <= iter_r - 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// File: src/sliding_window_rms_filter_unit.sv
// Top level: ring read-modify-write, window total, configuration and result register.
//
//   channel | direction | beat handshake        | payload
//   in      | input     | in_valid / in_stall   | in_sample
//   out     | output    | out_valid / out_stall | out_rms
//   cfg     | input     | cfg_we (no wait)      | cfg_index, cfg_wdata
//
// A result is registered once the divider has produced one quotient bit per cycle and then
// one root bit per cycle. No new beat is taken until the previous result is in the output
// register. The ring is read the cycle a beat is taken and written back the next cycle.
// Reset needs no clearing pass; a configuration write stalls input in its own cycle and
// while prime1_r and prime2_r carry it on to the re-priming of the window total. A waiting
// result sits in the output register while the next beat is taken.
`timescale 1ns / 1ps

module sliding_window_rms_filter_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [swrms_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [swrms_pkg::RMS_W-1:0]         out_rms,
  input  logic                                cfg_we,
  input  logic [swrms_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [swrms_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import swrms_pkg::*;

  ctrl_state_t state_r, state_nxt;

  logic [WL_W-1:0]         window_length_r;
  logic signed [PL_W-1:0]  prime_level_r;
  logic                    prime1_r;
  logic                    prime2_r;
  logic [SQ_W-1:0]         prime_sq_r;
  logic [PTR_W-1:0]        ptr_r;
  logic [CNT_W-1:0]        fill_r;
  logic [TOT_W-1:0]        total_r;
  logic [PTR_W-1:0]        addr_r;
  logic [SQ_W-1:0]         sq_r;
  logic                    out_valid_r;
  logic [RMS_W-1:0]        out_rms_r;

  logic [CNT_W-1:0]           eff_n;
  logic [PTR_W-1:0]           ptr_eff;
  logic [CNT_W-1:0]           ptr_inc;
  logic [PTR_W-1:0]           ptr_nxt;
  logic [SAMPLE_BITS-1:0]     mag;
  logic [2*SAMPLE_BITS-1:0]   sample_sq;
  logic [PL_W-1:0]            prime_mag;
  logic [2*PL_W-1:0]          prime_sq;
  logic [CNT_W+SQ_W-1:0]      prime_prod;
  logic [SQ_W-1:0]            rdata;
  logic [SQ_W-1:0]            old_sq;
  logic [TOT_W-1:0]           total_nxt;
  logic [ROOT_W+RMS_W-1:0]    root_x;
  logic [RMS_W-1:0]           rms_sat;

  logic    accept;
  logic    ram_we;
  logic    out_load;
  ds_req_t ds_req;
  ds_rsp_t ds_rsp;

  always_comb begin
    if (window_length_r == '0) begin
      eff_n = CNT_W'(1);
    end else if (32'(window_length_r) > 32'(WINDOW_MAX)) begin
      eff_n = CNT_W'(WINDOW_MAX);
    end else begin
      eff_n = CNT_W'(window_length_r);
    end
  end

  always_comb begin
    ptr_eff    = (CNT_W'(ptr_r) >= eff_n) ? '0 : ptr_r;
    ptr_inc    = CNT_W'(addr_r) + CNT_W'(1);
    ptr_nxt    = (ptr_inc >= eff_n) ? '0 : PTR_W'(ptr_inc);
    mag        = in_sample[SAMPLE_BITS-1] ? SAMPLE_BITS'(-in_sample) : SAMPLE_BITS'(in_sample);
    sample_sq  = {SAMPLE_BITS'(0), mag} * {SAMPLE_BITS'(0), mag};
    prime_mag  = prime_level_r[PL_W-1] ? PL_W'(-prime_level_r) : PL_W'(prime_level_r);
    prime_sq   = {PL_W'(0), prime_mag} * {PL_W'(0), prime_mag};
    prime_prod = {SQ_W'(0), eff_n} * {CNT_W'(0), prime_sq_r};
    old_sq     = (fill_r >= eff_n) ? rdata : prime_sq_r;
    total_nxt  = total_r - TOT_W'(old_sq) + TOT_W'(sq_r);
    root_x     = (ROOT_W + RMS_W)'(ds_rsp.root);
    rms_sat    = (root_x > (ROOT_W + RMS_W)'({RMS_W{1'b1}})) ? {RMS_W{1'b1}}
                                                               : RMS_W'(root_x);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        if (ds_rsp.done) state_nxt = ST_DELIVER;
      end
      ST_DELIVER: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall        = (state_r != ST_IDLE) || prime1_r || prime2_r || cfg_we;
    accept          = in_valid && !in_stall;
    ram_we          = (state_r == ST_UPDATE);
    ds_req.start    = (state_r == ST_UPDATE);
    ds_req.dividend = total_nxt;
    ds_req.divisor  = eff_n;
    out_load        = (state_r == ST_DELIVER) && (!out_valid_r || !out_stall);
    out_valid       = out_valid_r;
    out_rms         = out_rms_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      window_length_r <= WINDOW_RESET;
      prime_level_r   <= '0;
      prime1_r        <= 1'b0;
      prime2_r        <= 1'b0;
      prime_sq_r      <= '0;
      ptr_r           <= '0;
      fill_r          <= '0;
      total_r         <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      prime_sq_r <= SQ_W'(prime_sq);
      prime1_r   <= cfg_we;
      prime2_r   <= prime1_r;
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_LENGTH: window_length_r <= cfg_wdata[WL_W-1:0];
          REG_PRIME_LEVEL:   prime_level_r   <= cfg_wdata[PL_W-1:0];
          default: begin
          end
        endcase
      end
      if (prime2_r) begin
        ptr_r   <= '0;
        fill_r  <= '0;
        total_r <= TOT_W'(prime_prod);
      end else if (state_r == ST_UPDATE) begin
        ptr_r   <= ptr_nxt;
        total_r <= total_nxt;
        if (fill_r < eff_n) fill_r <= fill_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_r <= ptr_eff;
      sq_r   <= SQ_W'(sample_sq);
    end
    if (out_load) begin
      out_rms_r <= rms_sat;
    end
  end

  swrms_ram #(
    .DEPTH (WINDOW_MAX),
    .WIDTH (SQ_W)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (sq_r),
    .raddr (ptr_eff),
    .rdata (rdata)
  );

  swrms_divsqrt u_divsqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ds_req),
    .rsp   (ds_rsp)
  );

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the sliding-window RMS filter: random samples and window settings.
`timescale 1ns / 1ps

module tb_top;
  import swrms_pkg::*;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_sample = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [RMS_W-1:0]              out_rms;
  logic                          cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index = REG_WINDOW_LENGTH;
  logic [CFG_DATA_W-1:0]         cfg_wdata = '0;

  sliding_window_rms_filter_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rms   (out_rms),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Window mirror
  logic [WL_W-1:0]        win_len_reg;
  logic signed [PL_W-1:0] prime_reg;
  longint unsigned        sq_ring [WINDOW_MAX];
  int                     ring_ptr;
  int                     fill_cnt;
  longint unsigned        sq_total;

  logic signed [SAMPLE_BITS-1:0] sample_q [$];
  logic [RMS_W-1:0]              rms_q [$];

  int send_idle_pct = 35;
  int stall_pct     = 88;
  int err_count     = 0;
  int samples_sent  = 0;
  int rms_checked   = 0;
  int settings_cnt  = 0;

  function automatic int eff_window();
    if (win_len_reg == 0) return 1;
    if (win_len_reg > WINDOW_MAX) return WINDOW_MAX;
    return int'(win_len_reg);
  endfunction

  function automatic longint unsigned square_of(logic signed [15:0] s);
    longint m;
    m = s;
    if (m < 0) m = -m;
    return m * m;
  endfunction

  function automatic logic [RMS_W-1:0] floor_root(longint unsigned x);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 16; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    if (r > 65535) r = 65535;
    return r[RMS_W-1:0];
  endfunction

  function automatic void reprime();
    ring_ptr = 0;
    fill_cnt = 0;
    sq_total = longint'(eff_window()) * square_of(prime_reg);
  endfunction

  function automatic logic [RMS_W-1:0] advance_window(logic signed [SAMPLE_BITS-1:0] s);
    int              n;
    int              p;
    longint unsigned sq;
    longint unsigned oldest;
    n = eff_window();
    p = (ring_ptr >= n) ? 0 : ring_ptr;
    sq = square_of(s);
    oldest = (fill_cnt >= n) ? sq_ring[p] : square_of(prime_reg);
    sq_ring[p] = sq;
    sq_total = sq_total - oldest + sq;
    if (fill_cnt < n) fill_cnt++;
    p++;
    ring_ptr = (p >= n) ? 0 : p;
    return floor_root(sq_total / longint'(n));
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return SAMPLE_BITS'($signed($urandom_range(0, 31)) - 16);
      3: return prime_reg + SAMPLE_BITS'($signed($urandom_range(0, 7)) - 4);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WINDOW_LENGTH) win_len_reg = data[WL_W-1:0];
    else prime_reg = data[PL_W-1:0];
    reprime();
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || in_valid || rms_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_window(input logic [CFG_DATA_W-1:0] wl_data,
                            input logic [CFG_DATA_W-1:0] pl_data, input int mask);
    drain();
    settings_cnt++;
    if ($urandom_range(1)) begin
      if (mask[0]) write_reg(REG_WINDOW_LENGTH, wl_data);
      if (mask[1]) write_reg(REG_PRIME_LEVEL, pl_data);
    end else begin
      if (mask[1]) write_reg(REG_PRIME_LEVEL, pl_data);
      if (mask[0]) write_reg(REG_WINDOW_LENGTH, wl_data);
    end
  endtask

  task automatic report(input string what, input logic [RMS_W-1:0] want,
                        input logic [RMS_W-1:0] got);
    err_count++;
    if (err_count <= 10)
      $display("[%0t] %s: rms expected %0d, got %0d", $time, what, want, got);
  endtask

  // Sender: present queued samples, hold while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        rms_q.push_back(advance_window(in_sample));
        samples_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid  <= 1'b1;
          in_sample <= sample_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Receiver: compare each result beat with the oldest expectation
  always @(posedge clk) begin : rms_check
    logic [RMS_W-1:0] want;
    if (rst_n && out_valid && !out_stall) begin
      if (rms_q.size() == 0) begin
        report("unexpected beat", '0, out_rms);
      end else begin
        want = rms_q.pop_front();
        rms_checked++;
        if (want !== out_rms) report("mismatch", want, out_rms);
      end
    end
  end

  initial begin : stimulus
    logic signed [SAMPLE_BITS-1:0] opening [20];
    logic [CFG_DATA_W-1:0]         wl_data;
    logic [CFG_DATA_W-1:0]         pl_data;
    int                            wl;
    int                            mask;
    opening = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001, 16'shFFFF, 16'sh5555,
                16'shAAAA, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh007F,
                16'shFF80, 16'sh0100, 16'sh8001, 16'sh4000, 16'shC000, 16'sh0002,
                16'sh8000, 16'sh0000};
    win_len_reg = WINDOW_RESET;
    prime_reg   = '0;
    reprime();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    settings_cnt = 1;
    foreach (opening[i]) sample_q.push_back(opening[i]);

    for (int k = 0; k < 12; k++) begin
      if (k == 4) begin
        drain();
        send_idle_pct = 88;
        stall_pct     = 35;
      end else if (k == 8) begin
        drain();
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      mask = 3;
      case (k)
        0: begin wl_data = 16'h0001; pl_data = 16'h8000; end
        1: begin wl_data = 16'h0100; pl_data = 16'h7FFF; end
        2: begin wl_data = 16'h0000; pl_data = 16'h0000; end
        3: begin wl_data = 16'hFFFF; pl_data = 16'hFFFF; end
        4: begin wl_data = 16'h0101; pl_data = 16'h0001; end
        5: begin wl_data = '0; pl_data = CFG_DATA_W'($urandom); mask = 2; end
        default: begin
          wl = ($urandom_range(4) == 0) ? $urandom_range(0, 511) : $urandom_range(2, 40);
          wl_data = {7'($urandom), 9'(wl)};
          pl_data = CFG_DATA_W'($urandom);
          mask = $urandom_range(1, 3);
        end
      endcase
      set_window(wl_data, pl_data, mask);
      repeat ((k == 1) ? 300 : 58) sample_q.push_back(pick_sample());
    end
    drain();
    repeat (70) @(posedge clk);
    if (rms_q.size() != 0) begin
      err_count += rms_q.size();
      $display("%0d expected results never arrived", rms_q.size());
    end
    $display("Sent %0d samples under %0d window settings; %0d RMS results checked.",
             samples_sent, settings_cnt, rms_checked);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
